// ----- rtl/swl_pkg.sv -----
// Shared types, codes and constants of the stopwatch with lap store.
package swl_pkg;

  // Default number of lap entries in the store.
  localparam int LAP_DEPTH_DEFAULT = 64;

  // Field widths.
  localparam int TIME_W = 29;
  localparam int HOUR_W = 7;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int MS_W   = 10;
  localparam int NUM_W  = 7;
  localparam int MODE_W = 2;
  localparam int ACT_W  = 3;

  // Saturation point, 99:59:59.999, and the roll-over values of each digit group.
  localparam logic [TIME_W-1:0] ELAPSED_MAX = TIME_W'(359999999);
  localparam logic [HOUR_W-1:0] HOUR_LAST   = HOUR_W'(99);
  localparam logic [MIN_W-1:0]  MIN_LAST    = MIN_W'(59);
  localparam logic [SEC_W-1:0]  SEC_LAST    = SEC_W'(59);
  localparam logic [MS_W-1:0]   MS_LAST     = MS_W'(999);

  // Run modes.
  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PAUSE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESUME = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LAP    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESET  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd6;

  // Commands from the controller to the time counter.
  typedef struct packed {
    logic tick;
    logic clear;
  } time_ctl_t;

  // Current time, raw and split into clock digits.
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [MS_W-1:0]   millis;
  } time_val_t;

endpackage

// ----- rtl/stopwatch_with_lap_store.sv -----
// Top level of the millisecond stopwatch with lap store.
//
// Each input transfer carries one action and yields exactly one result transfer that
// shows the state after the action. Every action is answered directly except a read
// of a stored lap, which passes through the read state as the lap store has a registered
// read port. A new input transfer is taken when no lap read is pending and the result
// register is empty or is being taken in the same cycle, so the block sustains one item
// per cycle while the result side keeps up. The time fields and the mode come straight
// from the state registers, which only change when an item is taken. The lap store needs
// no clearing after reset: only laps below the stored count are ever read.
module stopwatch_with_lap_store
  import swl_pkg::*;
#(
  parameter int LAP_DEPTH = LAP_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // [2:0] action, [9:3] lap_select, [15:10] zero.
  input  logic [15:0]  s_tdata,
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] run_mode, [30:2] elapsed_ms, [37:31] hours, [43:38] minutes,
  // [49:44] seconds, [59:50] millis, [60] lap_ok, [67:61] lap_number,
  // [96:68] lap_split_ms, [125:97] lap_total_ms, [132:126] lap_count, [135:133] zero.
  output logic [135:0] m_tdata
);

  localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
  localparam int CW = $clog2(LAP_DEPTH + 1);
  localparam int XW = (CW > NUM_W) ? CW : NUM_W;
  localparam int DW = 2 * TIME_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t            state;
  logic [MODE_W-1:0] mode;
  logic [CW-1:0]     laps_stored;
  logic [TIME_W-1:0] last_lap_total;

  logic [ACT_W-1:0]  action;
  logic [NUM_W-1:0]  lap_select;
  logic              accept;
  logic              running;
  logic              lap_take;
  logic              read_hit;
  logic [XW-1:0]     sel_x;
  logic [CW:0]       lap_num_w;
  logic [NUM_W-1:0]  sel_m1;
  logic [NUM_W-1:0]  read_num;

  time_ctl_t         tctl;
  time_val_t         tv;

  logic [TIME_W-1:0] lap_split;
  logic [DW-1:0]     rd_data;

  logic              out_ok;
  logic [NUM_W-1:0]  out_num;
  logic [TIME_W-1:0] out_split;
  logic [TIME_W-1:0] out_total;

  assign action     = s_tdata[2:0];
  assign lap_select = s_tdata[9:3];

  // Handshake on the input side.
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign running  = (mode == MODE_RUNNING);

  // Decode of lap record and lap read.
  assign lap_take  = accept && (action == ACT_LAP) && running &&
                     (laps_stored < CW'(LAP_DEPTH));
  assign sel_x     = XW'(lap_select);
  assign read_hit  = accept && (action == ACT_READ) && (lap_select != '0) &&
                     (sel_x <= XW'(laps_stored)) && (sel_x <= XW'(LAP_DEPTH));
  assign sel_m1    = lap_select - NUM_W'(1);
  assign lap_num_w = {1'b0, laps_stored} + (CW + 1)'(1);
  assign lap_split = tv.elapsed - last_lap_total;

  // Commands to the time counter.
  assign tctl.tick  = accept && (action == ACT_TICK) && running;
  assign tctl.clear = accept && ((action == ACT_START) || (action == ACT_RESET));

  swl_time_cnt u_time (
    .clk (clk),
    .rst (rst),
    .ctl (tctl),
    .tv  (tv)
  );

  swl_lap_mem #(
    .DEPTH (LAP_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (lap_take),
    .wr_addr (laps_stored[AW-1:0]),
    .wr_data ({tv.elapsed, lap_split}),
    .rd_en   (read_hit),
    .rd_addr (AW'(sel_m1)),
    .rd_data (rd_data)
  );

  // Mode, lap count and the total of the previous lap.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_STOPPED;
      laps_stored    <= '0;
      last_lap_total <= '0;
    end else if (accept) begin
      case (action)
        ACT_START: begin
          mode           <= MODE_RUNNING;
          laps_stored    <= '0;
          last_lap_total <= '0;
        end
        ACT_PAUSE: begin
          if (running) begin
            mode <= MODE_PAUSED;
          end
        end
        ACT_RESUME: begin
          if (mode == MODE_PAUSED) begin
            mode <= MODE_RUNNING;
          end
        end
        ACT_LAP: begin
          if (lap_take) begin
            laps_stored    <= laps_stored + CW'(1);
            last_lap_total <= tv.elapsed;
          end
        end
        ACT_RESET: begin
          mode           <= MODE_STOPPED;
          laps_stored    <= '0;
          last_lap_total <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: a valid read waits in the read state while the store delivers its entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (read_hit) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Lap number of a pending read.
  always_ff @(posedge clk) begin
    if (read_hit) begin
      read_num <= lap_select;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((accept && !read_hit) || (state == ST_READ)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Lap fields of the result.
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      out_ok    <= 1'b1;
      out_num   <= read_num;
      out_split <= rd_data[TIME_W-1:0];
      out_total <= rd_data[DW-1:TIME_W];
    end else if (accept) begin
      out_ok    <= lap_take;
      out_num   <= lap_take ? NUM_W'(lap_num_w) : '0;
      out_split <= lap_take ? lap_split : '0;
      out_total <= lap_take ? tv.elapsed : '0;
    end
  end

  assign m_tdata = {3'b000, NUM_W'(laps_stored), out_total, out_split, out_num, out_ok,
                    tv.millis, tv.seconds, tv.minutes, tv.hours, tv.elapsed, mode};

  // The raw count never passes the saturation point.
  a_elapsed_max: assert property (@(posedge clk) disable iff (rst)
    tv.elapsed <= ELAPSED_MAX)
    else $error("elapsed time above saturation point");

  // The clock digits stay within their ranges.
  a_digits: assert property (@(posedge clk) disable iff (rst)
    (tv.millis <= MS_LAST) && (tv.seconds <= SEC_LAST) && (tv.minutes <= MIN_LAST) &&
    (tv.hours <= HOUR_LAST))
    else $error("clock digit out of range");

  // The lap count never exceeds the store depth.
  a_lap_count: assert property (@(posedge clk) disable iff (rst)
    laps_stored <= CW'(LAP_DEPTH))
    else $error("lap count above store depth");

  // A recorded lap raises the count by one.
  a_lap_inc: assert property (@(posedge clk) disable iff (rst)
    lap_take |=> (laps_stored == $past(laps_stored) + CW'(1)))
    else $error("lap count did not advance");

  // A read of the store always ends in a valid lap result.
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (m_tvalid && out_ok))
    else $error("lap read produced no result");

endmodule

// ----- rtl/swl_lap_mem.sv -----
// Lap store: one write port and one registered read port.
module swl_lap_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 58
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/swl_time_cnt.sv -----
// Elapsed time counter that keeps the raw count and the clock digits side by side.
module swl_time_cnt
  import swl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  time_ctl_t ctl,
  output time_val_t tv
);

  logic [TIME_W-1:0] elapsed;
  logic [HOUR_W-1:0] hours;
  logic [MIN_W-1:0]  minutes;
  logic [SEC_W-1:0]  seconds;
  logic [MS_W-1:0]   millis;
  logic              step;

  // A tick only counts while the time is below the saturation point.
  assign step = ctl.tick && (elapsed != ELAPSED_MAX);

  // Count with carries from milliseconds up to hours.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      elapsed <= '0;
      hours   <= '0;
      minutes <= '0;
      seconds <= '0;
      millis  <= '0;
    end else if (step) begin
      elapsed <= elapsed + TIME_W'(1);
      if (millis != MS_LAST) begin
        millis <= millis + MS_W'(1);
      end else begin
        millis <= '0;
        if (seconds != SEC_LAST) begin
          seconds <= seconds + SEC_W'(1);
        end else begin
          seconds <= '0;
          if (minutes != MIN_LAST) begin
            minutes <= minutes + MIN_W'(1);
          end else begin
            minutes <= '0;
            hours   <= hours + HOUR_W'(1);
          end
        end
      end
    end
  end

  assign tv.elapsed = elapsed;
  assign tv.hours   = hours;
  assign tv.minutes = minutes;
  assign tv.seconds = seconds;
  assign tv.millis  = millis;

endmodule
